// ===== hdl/frwa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frwa_pkg
// Shared types and constants of the frame rate window averager.
// ----------------------------------------------------------------------------
package frwa_pkg;

    localparam int TIME_W    = 32;
    localparam int TGT_W     = 10;
    localparam int FPS_W     = 22;
    localparam int DT_W      = 32;
    localparam int DELAY_W   = 10;

    localparam int WINDOW_DEF = 10;

    localparam int FPS_SCALE = 256000;
    localparam int MS_PER_S  = 1000;

    // Numerator widths of the period and budget divisions
    localparam int PER_NUM_W = 20;
    localparam int BUD_NUM_W = 10;

    localparam logic [TGT_W-1:0]     TGT_RESET   = TGT_W'(120);
    localparam logic [FPS_W-1:0]     FPS_MAX     = {FPS_W{1'b1}};
    localparam logic [FPS_W-1:0]     FPS_DEFAULT = FPS_W'(15360);
    localparam logic [DT_W-1:0]      DT_DEFAULT  = DT_W'(16667);
    localparam logic [PER_NUM_W-1:0] US_PER_S    = PER_NUM_W'(1000000);
    // 1000 placed at the top of the period numerator field
    localparam logic [PER_NUM_W-1:0] BUD_NUM_ALIGNED =
        PER_NUM_W'(MS_PER_S) << (PER_NUM_W - BUD_NUM_W);

    typedef struct packed {
        logic              action;
        logic [TIME_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [FPS_W-1:0]   fps_q8;
        logic [DT_W-1:0]    delta_time_us;
        logic [DELAY_W-1:0] delay_ms;
    } t_out_item;

    localparam logic ACT_BEGIN = 1'b0;
    localparam logic ACT_END   = 1'b1;

endpackage

// ===== hdl/frwa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frwa_div
// Bit-serial restoring divider: one quotient bit per cycle, the numerator
// taken MSB first from a shift register for a given number of bits.
// ----------------------------------------------------------------------------
module frwa_div #(
    parameter int NW = 46,
    parameter int DW = 36
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [$clog2(NW+1)-1:0]  i_bits,
    input  logic [NW-1:0]            i_num,
    input  logic [DW-1:0]            i_div,
    output logic                     o_busy,
    output logic [NW-1:0]            o_quot
);

    localparam int BW = $clog2(NW + 1);

    logic [NW-1:0] r_num;
    logic [NW-1:0] r_quot;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic [BW-1:0] r_left;
    logic          r_busy;

    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;
    logic [DW-1:0] n_rem;

    assign w_trial = {r_rem, r_num[NW-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = w_trial >= {1'b0, r_div};
    // Remainder stays below the divisor, so the difference fits DW bits
    assign n_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
        end else if (i_start) begin
            r_busy <= (i_bits != '0);
            r_left <= i_bits;
        end else if (r_busy) begin
            r_busy <= (r_left != BW'(1));
            r_left <= r_left - BW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_div  <= i_div;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= r_num << 1;
            r_rem  <= n_rem;
            r_quot <= {r_quot[NW-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

`ifndef ASSERT_OFF
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_div != '0 |-> r_rem < r_div)
        else $error("frwa_div: remainder not below divisor");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && i_bits != '0 |=> r_busy)
        else $error("frwa_div: start did not raise busy");
    a_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_start && r_left == BW'(1) |=> !r_busy)
        else $error("frwa_div: busy past the last bit");
`endif

endmodule

// ===== hdl/frame_rate_window_averager_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_rate_window_averager_unit
// Frame rate meter over a sliding window of frame-end intervals.
// ----------------------------------------------------------------------------
// A begin item is taken without leaving the idle state and gives no result. An
// end item updates the interval ring (kept in a small memory) and the running
// sum in the states SUB and ADD, forms the numerators in MUL, then runs two
// bit-serial dividers side by side in two rounds: count/sum for the frame rate
// with the target period next to it, then sum/count for the averaged frame time
// with the frame budget next to it. Each round lasts until both dividers have
// given all their bits. The result waits in an output register; the next item
// is taken once the result is loaded there, so a stalled output holds it back.
// ----------------------------------------------------------------------------
module frame_rate_window_averager_unit #(
    parameter int WINDOW = frwa_pkg::WINDOW_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  frwa_pkg::t_in_item           i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output frwa_pkg::t_out_item          o_out_item,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [frwa_pkg::TGT_W-1:0]   i_cfg_data
);

    localparam int TIME_W    = frwa_pkg::TIME_W;
    localparam int TGT_W     = frwa_pkg::TGT_W;
    localparam int DT_W      = frwa_pkg::DT_W;
    localparam int FPS_W     = frwa_pkg::FPS_W;
    localparam int DELAY_W   = frwa_pkg::DELAY_W;
    localparam int PER_NUM_W = frwa_pkg::PER_NUM_W;
    localparam int BUD_NUM_W = frwa_pkg::BUD_NUM_W;
    localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int SUM_W     = TIME_W + CNT_W;
    localparam int AVG_NUM_W = SUM_W + 10;
    localparam int FPS_NUM_W = $clog2(frwa_pkg::FPS_SCALE * WINDOW + 1);
    localparam int B0_W      = $clog2(AVG_NUM_W + 1);
    localparam int B1_W      = $clog2(PER_NUM_W + 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SUB   = 9'b000000010,
        S_ADD   = 9'b000000100,
        S_MUL   = 9'b000001000,
        S_DIVA  = 9'b000010000,
        S_WAITA = 9'b000100000,
        S_DIVB  = 9'b001000000,
        S_WAITB = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [TGT_W-1:0]     r_tgt;
    logic [TGT_W-1:0]     w_tgt_eff;
    logic [TIME_W-1:0]    r_ring [WINDOW];
    logic [TIME_W-1:0]    r_rd;
    logic [SLOT_W-1:0]    r_slot;
    logic [CNT_W-1:0]     r_cnt;
    logic [SUM_W-1:0]     r_sum;
    logic [TIME_W-1:0]    r_last_end;
    logic                 r_last_valid;
    logic [TIME_W-1:0]    r_frame_start;
    logic [TIME_W-1:0]    r_interval;
    logic [TIME_W-1:0]    r_frame_ms;
    logic [FPS_NUM_W-1:0] r_fps_num;
    logic [AVG_NUM_W-1:0] r_avg_num;
    logic [AVG_NUM_W-1:0] w_sum_x;
    logic [FPS_W-1:0]     r_fps;
    logic [PER_NUM_W-1:0] r_period;
    logic                 r_out_valid;
    frwa_pkg::t_out_item  r_out_item;

    logic                 w_in_acc;
    logic                 w_out_free;
    logic                 w_sum_zero;
    logic                 w_full;

    logic                 w_start;
    logic [B0_W-1:0]      w_bits0;
    logic [AVG_NUM_W-1:0] w_num0;
    logic [SUM_W-1:0]     w_div0;
    logic                 w_busy0;
    logic [AVG_NUM_W-1:0] w_quot0;
    logic [B1_W-1:0]      w_bits1;
    logic [PER_NUM_W-1:0] w_num1;
    logic                 w_busy1;
    logic [PER_NUM_W-1:0] w_quot1;

    logic [DT_W-1:0]      w_avg_sat;
    logic [DT_W-1:0]      w_period_ext;
    logic [DT_W-1:0]      w_dt;
    logic [BUD_NUM_W-1:0] w_budget;
    logic [DELAY_W-1:0]   w_delay;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_sum_zero  = (r_sum == '0);
    assign w_full      = (r_cnt == CNT_W'(WINDOW));
    assign w_tgt_eff   = (r_tgt == '0) ? TGT_W'(1) : r_tgt;

    // ---- control ----------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_acc && i_in_item.action == frwa_pkg::ACT_END) begin
                n_state = S_SUB;
            end
            S_SUB:   n_state = S_ADD;
            S_ADD:   n_state = S_MUL;
            S_MUL:   n_state = S_DIVA;
            S_DIVA:  n_state = S_WAITA;
            S_WAITA: if (!w_busy0 && !w_busy1) begin
                n_state = S_DIVB;
            end
            S_DIVB:  n_state = S_WAITB;
            S_WAITB: if (!w_busy0 && !w_busy1) begin
                n_state = S_OUT;
            end
            S_OUT:   if (w_out_free) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tgt        <= frwa_pkg::TGT_RESET;
            r_slot       <= '0;
            r_cnt        <= '0;
            r_sum        <= '0;
            r_last_end   <= '0;
            r_last_valid <= 1'b0;
            r_frame_start <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_tgt <= i_cfg_data;
            end
            if (w_in_acc) begin
                if (i_in_item.action == frwa_pkg::ACT_END) begin
                    r_last_end   <= i_in_item.now_ms;
                    r_last_valid <= 1'b1;
                end else begin
                    r_frame_start <= i_in_item.now_ms;
                end
            end
            // drop the oldest interval once the window is full
            if (r_state == S_SUB && w_full) begin
                r_sum <= r_sum - SUM_W'(r_rd);
            end
            if (r_state == S_ADD) begin
                r_sum  <= r_sum + SUM_W'(r_interval);
                r_slot <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + SLOT_W'(1);
                if (!w_full) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---- interval ring ----------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_state == S_ADD) begin
            r_ring[r_slot] <= r_interval;
        end
        r_rd <= r_ring[r_slot];
    end

    // x * 1000 as shifts and subtracts
    assign w_sum_x = (AVG_NUM_W'(r_sum) << 10) - (AVG_NUM_W'(r_sum) << 4)
                   - (AVG_NUM_W'(r_sum) << 3);

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_in_item.action == frwa_pkg::ACT_END) begin
            r_interval <= r_last_valid ? i_in_item.now_ms - r_last_end : '0;
            r_frame_ms <= i_in_item.now_ms - r_frame_start;
        end
        if (r_state == S_MUL) begin
            r_avg_num <= w_sum_x;
            r_fps_num <= FPS_NUM_W'(r_cnt) * FPS_NUM_W'(frwa_pkg::FPS_SCALE);
        end
        if (r_state == S_DIVB) begin
            if (w_sum_zero) begin
                r_fps <= frwa_pkg::FPS_DEFAULT;
            end else if (w_quot0 > AVG_NUM_W'(frwa_pkg::FPS_MAX)) begin
                r_fps <= frwa_pkg::FPS_MAX;
            end else begin
                r_fps <= w_quot0[FPS_W-1:0];
            end
            r_period <= w_quot1;
        end
        if (r_state == S_OUT && w_out_free) begin
            r_out_item.fps_q8        <= r_fps;
            r_out_item.delta_time_us <= w_dt;
            r_out_item.delay_ms      <= w_delay;
        end
    end

    // ---- dividers ---------------------------------------------------------
    // Round A: rate and target period. Round B: frame time and frame budget.
    assign w_start = (r_state == S_DIVA) || (r_state == S_DIVB);

    always_comb begin
        if (r_state == S_DIVA) begin
            w_bits0 = B0_W'(FPS_NUM_W);
            w_num0  = AVG_NUM_W'(r_fps_num) << (AVG_NUM_W - FPS_NUM_W);
            w_div0  = r_sum;
            w_bits1 = B1_W'(PER_NUM_W);
            w_num1  = frwa_pkg::US_PER_S;
        end else begin
            w_bits0 = B0_W'(AVG_NUM_W);
            w_num0  = r_avg_num;
            w_div0  = SUM_W'(r_cnt);
            w_bits1 = B1_W'(BUD_NUM_W);
            w_num1  = frwa_pkg::BUD_NUM_ALIGNED;
        end
    end

    frwa_div #(
        .NW (AVG_NUM_W),
        .DW (SUM_W)
    ) u_div_avg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_bits  (w_bits0),
        .i_num   (w_num0),
        .i_div   (w_div0),
        .o_busy  (w_busy0),
        .o_quot  (w_quot0)
    );

    frwa_div #(
        .NW (PER_NUM_W),
        .DW (TGT_W)
    ) u_div_tgt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_bits  (w_bits1),
        .i_num   (w_num1),
        .i_div   (w_tgt_eff),
        .o_busy  (w_busy1),
        .o_quot  (w_quot1)
    );

    // ---- result -----------------------------------------------------------
    always_comb begin
        if (w_sum_zero) begin
            w_avg_sat = frwa_pkg::DT_DEFAULT;
        end else if (|w_quot0[AVG_NUM_W-1:DT_W]) begin
            w_avg_sat = '1;
        end else begin
            w_avg_sat = w_quot0[DT_W-1:0];
        end
    end

    assign w_period_ext = DT_W'(r_period);
    assign w_dt         = (w_avg_sat > w_period_ext) ? w_avg_sat : w_period_ext;
    assign w_budget     = w_quot1[BUD_NUM_W-1:0];
    // budget is at most 1000, so a frame time below it fits the delay width
    assign w_delay      = (TIME_W'(w_budget) > r_frame_ms)
                        ? DELAY_W'(w_budget) - r_frame_ms[DELAY_W-1:0] : '0;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(WINDOW))
        else $error("frwa: fill count beyond window");
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_W'(WINDOW - 1))
        else $error("frwa: write slot beyond window");
    a_out_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_cnt != '0)
        else $error("frwa: result with empty window");
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && w_out_free |=> o_out_valid && r_state == S_IDLE)
        else $error("frwa: result not loaded");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for frame_rate_window_averager_unit. Timestamped frame
// begin and end items go in, and every averaged rate, frame time and delay
// that comes out is checked against a predictor of the interval window.
// ----------------------------------------------------------------------------
module tb;

    localparam int WIN           = frwa_pkg::WINDOW_DEF;
    localparam int SETTLE_CYCLES = 100;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_in_valid  = 1'b0;
    logic                         o_in_stall;
    frwa_pkg::t_in_item           i_in_item   = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    frwa_pkg::t_out_item          o_out_item;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [frwa_pkg::TGT_W-1:0]   i_cfg_data  = '0;

    frame_rate_window_averager_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predicted state of the averaging window
    logic [frwa_pkg::TIME_W-1:0] ring_ms [WIN] = '{default: '0};
    int unsigned                 slot          = 0;
    int unsigned                 filled        = 0;
    logic [63:0]                 sum_ms        = '0;
    logic [frwa_pkg::TIME_W-1:0] last_end_ms   = '0;
    bit                          last_end_seen = 1'b0;
    logic [frwa_pkg::TIME_W-1:0] start_ms      = '0;
    logic [frwa_pkg::TGT_W-1:0]  target_fps    = frwa_pkg::TGT_RESET;

    frwa_pkg::t_in_item  frame_events [$];
    frwa_pkg::t_out_item expected_stats [$];

    bit                          gaps_on       = 1'b1;
    logic [frwa_pkg::TIME_W-1:0] clock_ms      = '0;
    int                          mismatches    = 0;
    int                          begins_sent   = 0;
    int                          ends_sent     = 0;
    int                          results_seen  = 0;

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("tb: mismatch in %s at result %0d: got %0d, expected %0d",
                 what, results_seen, got, want);
        mismatches++;
    endtask

    function automatic bit predict_frame_stats(input frwa_pkg::t_in_item ev,
                                               output frwa_pkg::t_out_item res);
        logic [31:0] interval;
        logic [31:0] frame_ms;
        logic [31:0] tgt;
        logic [31:0] period_us;
        logic [31:0] budget_ms;
        logic [31:0] delay;
        logic [63:0] fps;
        logic [63:0] avg_us;
        logic [63:0] dt;
        res = '0;
        if (ev.action == frwa_pkg::ACT_BEGIN) begin
            start_ms = ev.now_ms;
            return 1'b0;
        end
        interval      = last_end_seen ? ev.now_ms - last_end_ms : '0;
        last_end_ms   = ev.now_ms;
        last_end_seen = 1'b1;

        // Drop the oldest interval once the window is full
        if (filled >= WIN) sum_ms -= ring_ms[slot];
        ring_ms[slot] = interval;
        sum_ms += interval;
        slot = (slot + 1) % WIN;
        if (filled < WIN) filled++;

        tgt       = (target_fps == 0) ? 32'd1 : 32'(target_fps);
        period_us = 32'd1000000 / tgt;
        if (sum_ms == 0) begin
            fps    = 64'(frwa_pkg::FPS_DEFAULT);
            avg_us = 64'(frwa_pkg::DT_DEFAULT);
        end else begin
            fps = (64'(frwa_pkg::FPS_SCALE) * 64'(filled)) / sum_ms;
            if (fps > 64'(frwa_pkg::FPS_MAX)) fps = 64'(frwa_pkg::FPS_MAX);
            avg_us = (sum_ms * 64'd1000) / 64'(filled);
        end
        dt = (avg_us > 64'(period_us)) ? avg_us : 64'(period_us);
        if (dt > 64'hFFFF_FFFF) dt = 64'hFFFF_FFFF;

        frame_ms  = ev.now_ms - start_ms;
        budget_ms = 32'd1000 / tgt;
        delay     = (budget_ms > frame_ms) ? budget_ms - frame_ms : '0;

        res.fps_q8        = fps[frwa_pkg::FPS_W-1:0];
        res.delta_time_us = dt[frwa_pkg::DT_W-1:0];
        res.delay_ms      = delay[frwa_pkg::DELAY_W-1:0];
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : drive_events
        frwa_pkg::t_out_item stats;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                if (predict_frame_stats(i_in_item, stats)) begin
                    expected_stats.push_back(stats);
                    ends_sent++;
                end else begin
                    begins_sent++;
                end
            end
            if (frame_events.size() != 0 && !(gaps_on && $urandom_range(99) < 19)) begin
                i_in_valid <= 1'b1;
                i_in_item  <= frame_events.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        frwa_pkg::t_out_item want;
        i_out_stall <= gaps_on && ($urandom_range(99) < 19);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_stats.size() == 0) begin
                report_mismatch("result with no frame end pending", o_out_item, 0);
            end else begin
                want = expected_stats.pop_front();
                if (o_out_item.fps_q8 !== want.fps_q8)
                    report_mismatch("fps_q8", o_out_item.fps_q8, want.fps_q8);
                if (o_out_item.delta_time_us !== want.delta_time_us)
                    report_mismatch("delta_time_us", o_out_item.delta_time_us,
                                    want.delta_time_us);
                if (o_out_item.delay_ms !== want.delay_ms)
                    report_mismatch("delay_ms", o_out_item.delay_ms, want.delay_ms);
                results_seen++;
            end
        end
    end

    task automatic push_event(input logic action,
                              input logic [frwa_pkg::TIME_W-1:0] now_ms);
        frwa_pkg::t_in_item ev;
        ev.action = action;
        ev.now_ms = now_ms;
        frame_events.push_back(ev);
    endtask

    // Hold until every queued item is sent and every result is back; look at
    // the falling edge so the driver's updates have landed
    task automatic drain();
        do @(negedge i_clk);
        while (frame_events.size() != 0 || i_in_valid || expected_stats.size() != 0);
    endtask

    // A begin item gives no result, so let it finish before touching config
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_target(input logic [frwa_pkg::TGT_W-1:0] fps);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= fps;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        target_fps = fps;
    endtask

    task automatic queue_random_frames(input int count);
        int          pushed;
        int          mode;
        int          burst;
        logic [31:0] t_end;
        pushed = 0;
        while (pushed < count) begin
            mode = $urandom_range(99);
            if (mode < 70) begin
                push_event(frwa_pkg::ACT_BEGIN, clock_ms);
                t_end = clock_ms + $urandom_range(0, 40);
                push_event(frwa_pkg::ACT_END, t_end);
                clock_ms = t_end + $urandom_range(0, 12);
                pushed += 2;
            end else if (mode < 78) begin
                // Repeated end times drive the interval sum back to zero
                burst = $urandom_range(1, 12);
                repeat (burst) push_event(frwa_pkg::ACT_END, clock_ms);
                pushed += burst;
            end else if (mode < 92) begin
                push_event(1'($urandom_range(1)), $urandom);
                pushed++;
            end else begin
                clock_ms = $urandom_range(1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 60);
            end
        end
    endtask

    initial begin : stimulus
        logic [frwa_pkg::TGT_W-1:0] targets [6];
        targets = '{10'd1000, 10'd0, 10'd1023, 10'd1, 10'($urandom_range(2, 999)),
                    frwa_pkg::TGT_RESET};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // End with no earlier end and no begin
        push_event(frwa_pkg::ACT_END, 32'd5);
        push_event(frwa_pkg::ACT_BEGIN, 32'd100);
        push_event(frwa_pkg::ACT_END, 32'd100);
        // Frame longer than the budget
        push_event(frwa_pkg::ACT_BEGIN, 32'd200);
        push_event(frwa_pkg::ACT_END, 32'd216);
        // Frame time and interval across the counter wrap
        push_event(frwa_pkg::ACT_BEGIN, 32'hFFFF_FFF0);
        push_event(frwa_pkg::ACT_END, 32'h0000_0005);
        // Huge interval saturates the frame time
        push_event(frwa_pkg::ACT_BEGIN, 32'h0000_0000);
        push_event(frwa_pkg::ACT_END, 32'hFFFF_FFFF);
        push_event(frwa_pkg::ACT_END, 32'h0000_0000);
        // Fill the window and push the huge interval out
        for (int t = 1; t <= 10; t++) push_event(frwa_pkg::ACT_END, 32'(t));
        push_event(frwa_pkg::ACT_END, 32'd10);
        push_event(frwa_pkg::ACT_END, 32'd10);
        settle();

        clock_ms = $urandom;
        foreach (targets[p]) begin
            set_target(targets[p]);
            gaps_on = (p != 2);
            queue_random_frames(40);
            if (p == 3) drain();
            queue_random_frames(40);
            settle();
        end
        gaps_on = 1'b1;

        if (expected_stats.size() != 0)
            report_mismatch("frame ends left without a result", expected_stats.size(), 0);
        $display("tb: sent %0d frame begins and %0d frame ends, checked %0d results",
                 begins_sent, ends_sent, results_seen);
        $display("tb: targets 0, 1, 120, 1000, 1023 and one random; time wrap, full window, zero sum");
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== frame_rate_window_averager_unit.f =====
hdl/frwa_pkg.sv
hdl/frwa_div.sv
hdl/frame_rate_window_averager_unit.sv
tb/sv/tb.sv
